### sv/ttli_pkg.sv
// Shared constants, codes and types of the trilinear table interpolator.
package ttli_pkg;

  localparam int MAX_ROWS       = 8;
  localparam int MAX_INC_POINTS = 16;
  localparam int MAX_SPD_POINTS = 32;
  localparam int MAX_DIR_POINTS = 32;

  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int INC_W  = $clog2(MAX_INC_POINTS);
  localparam int SPD_W  = $clog2(MAX_SPD_POINTS);
  localparam int DIR_W  = $clog2(MAX_DIR_POINTS);
  localparam int NI_W   = $clog2(MAX_INC_POINTS + 1);
  localparam int NS_W   = $clog2(MAX_SPD_POINTS + 1);
  localparam int ND_W   = $clog2(MAX_DIR_POINTS + 1);
  localparam int ADDR_W = ROW_W + INC_W + SPD_W + DIR_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int CR_W   = 16 + ND_W;

  localparam int VAL_W = 32;
  // interpolation weight, Q.16 signed, may exceed one or go negative
  localparam int WGT_W = 34;

  typedef enum logic [1:0] {
    ACT_WRITE   = 2'd0,
    ACT_NEAREST = 2'd1,
    ACT_TRILIN  = 2'd2,
    ACT_MAXDIR  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_KIND = 2'd1,
    ST_NO_ROW   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    CFG_INC_MIN   = 3'd0,
    CFG_INC_SCALE = 3'd1,
    CFG_INC_PTS   = 3'd2,
    CFG_SPD_MIN   = 3'd3,
    CFG_SPD_SCALE = 3'd4,
    CFG_SPD_PTS   = 3'd5,
    CFG_DIR_PTS   = 3'd6,
    CFG_ROWS      = 3'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_MULT,
    S_INDEX,
    S_READ,
    S_DRAIN,
    S_LERP,
    S_WAIT,
    S_FIN
  } state_t;

  typedef struct packed {
    logic                    start;
    logic signed [VAL_W-1:0] lo;
    logic signed [VAL_W-1:0] hi;
    logic signed [WGT_W-1:0] wgt;
  } lerp_req_t;

  localparam int LAST_LERP_STEP = 6;

endpackage

### sv/ttli_ram.sv
// Generic single-port synchronous RAM with registered read.
module ttli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### sv/ttli_lerp.sv
// Four-stage linear interpolation unit: lo + w*(hi-lo), rounded, saturated.
module ttli_lerp (
  input  logic                clk,
  input  logic                rst,
  input  ttli_pkg::lerp_req_t req,
  output logic                done,
  output logic signed [ttli_pkg::VAL_W-1:0] result
);
  import ttli_pkg::*;

  logic [3:0] vld;

  logic signed [VAL_W:0]   diff1, diff2;
  logic signed [VAL_W-1:0] lo1, lo2;
  logic signed [WGT_W-1:0] wgt1;
  logic signed [17:0]      wh2;
  logic signed [49:0]      pl3;
  logic signed [50:0]      ph4;
  logic signed [33:0]      q4;
  logic signed [VAL_W-1:0] lo4;
  logic signed [51:0]      sum;
  logic signed [49:0]      pl_rnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[2:0], req.start};
    end
  end

  assign pl_rnd = pl3 + 50'sd32768;

  always_ff @(posedge clk) begin
    // stage 1: difference
    diff1 <= $signed({req.hi[VAL_W-1], req.hi}) - $signed({req.lo[VAL_W-1], req.lo});
    lo1   <= req.lo;
    wgt1  <= req.wgt;
    // stage 2: fractional weight product
    pl3   <= $signed({1'b0, wgt1[15:0]}) * diff1;
    wh2   <= wgt1[WGT_W-1:16];
    diff2 <= diff1;
    lo2   <= lo1;
    // stage 3: integer weight product, round fractional part
    ph4   <= wh2 * diff2;
    q4    <= pl_rnd[49:16];
    lo4   <= lo2;
  end

  assign sum = 52'(lo4) + 52'(ph4) + 52'(q4);

  always_ff @(posedge clk) begin
    if (sum > 52'sd2147483647) begin
      result <= 32'sh7FFFFFFF;
    end else if (sum < -52'sd2147483648) begin
      result <= 32'sh80000000;
    end else begin
      result <= sum[VAL_W-1:0];
    end
  end

  assign done = vld[3];

endmodule

### sv/trilinear_table_interpolator.sv
// Top level: command sequencer, index arithmetic and table memory.
// One item is taken when start is high and busy is low; its single result appears
// on result_value/status for one cycle with done high and cannot be held off.
// The table lives in one single-port memory read once per cycle, and every
// interpolation step goes through one four-stage lerp unit, so timing is set by
// those two: a write or a bad kind ends after the prepare state, a nearest lookup
// makes one read, a trilinear lookup makes 8 reads and 7 lerp steps, and the
// maximum mode repeats the reads and lerps once per direction point.
// Table content is undefined until written.
module trilinear_table_interpolator (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [2:0]  meas_kind,
  input  logic signed [23:0] incidence,
  input  logic signed [23:0] speed,
  input  logic [15:0] direction,
  input  logic [2:0]  write_row,
  input  logic [3:0]  write_inc_index,
  input  logic [4:0]  write_spd_index,
  input  logic [4:0]  write_dir_index,
  input  logic signed [31:0] entry_value,
  output logic        done,
  output logic signed [31:0] result_value,
  output logic [1:0]  status,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import ttli_pkg::*;

  // configuration
  logic signed [23:0] inc_min, spd_min;
  logic [23:0]        inc_scale, spd_scale;
  logic [4:0]         inc_pts;
  logic [5:0]         spd_pts, dir_pts;
  logic [3:0]         rows_pres;

  always_ff @(posedge clk) begin
    if (rst) begin
      inc_min   <= '0;
      inc_scale <= 24'd65536;
      inc_pts   <= 5'd16;
      spd_min   <= '0;
      spd_scale <= 24'd65536;
      spd_pts   <= 6'd32;
      dir_pts   <= 6'd32;
      rows_pres <= 4'd5;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_INC_MIN:   inc_min   <= cfg_data;
        CFG_INC_SCALE: inc_scale <= cfg_data;
        CFG_INC_PTS:   inc_pts   <= cfg_data[4:0];
        CFG_SPD_MIN:   spd_min   <= cfg_data;
        CFG_SPD_SCALE: spd_scale <= cfg_data;
        CFG_SPD_PTS:   spd_pts   <= cfg_data[5:0];
        CFG_DIR_PTS:   dir_pts   <= cfg_data[5:0];
        CFG_ROWS:      rows_pres <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // clamped point counts
  logic [NI_W-1:0] ni;
  logic [NS_W-1:0] ns;
  logic [ND_W-1:0] nd;

  always_comb begin
    if (inc_pts < 5'd2) begin
      ni = NI_W'(2);
    end else if (inc_pts > MAX_INC_POINTS) begin
      ni = NI_W'(MAX_INC_POINTS);
    end else begin
      ni = NI_W'(inc_pts);
    end
    if (spd_pts < 6'd2) begin
      ns = NS_W'(2);
    end else if (spd_pts > MAX_SPD_POINTS) begin
      ns = NS_W'(MAX_SPD_POINTS);
    end else begin
      ns = NS_W'(spd_pts);
    end
    if (dir_pts < 6'd1) begin
      nd = ND_W'(1);
    end else if (dir_pts > MAX_DIR_POINTS) begin
      nd = ND_W'(MAX_DIR_POINTS);
    end else begin
      nd = ND_W'(dir_pts);
    end
  end

  state_t state, state_next;

  // latched item
  action_t            act;
  logic [2:0]         kind_q;
  logic signed [23:0] inc_q, spd_q;
  logic [15:0]        dir_q;
  logic [2:0]         wrow_q;
  logic [3:0]         winc_q;
  logic [4:0]         wspd_q, wdir_q;
  logic signed [31:0] wval_q;

  logic [ROW_W-1:0]   row_q;
  logic signed [24:0] d_inc, d_spd;
  logic [CR_W-1:0]    cr;
  logic signed [33:0] ri, rs;

  logic [INC_W-1:0]   li;
  logic [SPD_W-1:0]   ls;
  logic [DIR_W-1:0]   lc, hc, cur_c;
  logic [15:0]        wd;
  logic signed [WGT_W-1:0] wi, ws;

  logic [2:0]         rd_cnt, rd_last, rd_idx;
  logic               rd_vld;
  logic signed [VAL_W-1:0] vals [8];
  logic signed [VAL_W-1:0] t0, t1, u0, u1, best;
  logic [2:0]         lstep;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_addr;
  logic [VAL_W-1:0]   ram_rdata;
  lerp_req_t          lreq;
  logic               lerp_done;
  logic signed [VAL_W-1:0] lerp_res;

  logic [2:0] kind_row;
  logic       kind_bad, row_missing, wr_ok;
  assign kind_row    = (kind_q > 3'd3) ? 3'd4 : kind_q;
  assign kind_bad    = kind_q > 3'd5;
  assign row_missing = {1'b0, kind_row} >= rows_pres;
  assign wr_ok = (wrow_q < MAX_ROWS) && (winc_q < MAX_INC_POINTS) &&
                 (wspd_q < MAX_SPD_POINTS) && (wdir_q < MAX_DIR_POINTS);

  logic last_c;
  assign last_c = ({1'b0, cur_c} == ND_W'(nd - 1'b1));

  // index arithmetic for the INDEX state
  logic signed [33:0] ri_rnd, rs_rnd;
  logic signed [17:0] ni_near, ns_near, li_raw, ls_raw;
  logic [INC_W-1:0]   li_sel, ni_sel;
  logic [SPD_W-1:0]   ls_sel, ns_sel;
  logic [CR_W:0]      cr_rnd;
  logic [ND_W-1:0]    nc_raw;
  logic [DIR_W-1:0]   lc_dir, hc_dir, nc_sel, hc_zero;

  always_comb begin
    ri_rnd  = ri + 34'sd32768;
    rs_rnd  = rs + 34'sd32768;
    ni_near = ri_rnd[33:16];
    ns_near = rs_rnd[33:16];
    if (ni_near[17]) begin
      ni_sel = '0;
    end else if (ni_near > $signed(18'(ni - 1'b1))) begin
      ni_sel = INC_W'(ni - 1'b1);
    end else begin
      ni_sel = INC_W'(ni_near);
    end
    if (ns_near[17]) begin
      ns_sel = '0;
    end else if (ns_near > $signed(18'(ns - 1'b1))) begin
      ns_sel = SPD_W'(ns - 1'b1);
    end else begin
      ns_sel = SPD_W'(ns_near);
    end
    li_raw = ri[33:16];
    ls_raw = rs[33:16];
    if (li_raw[17]) begin
      li_sel = '0;
    end else if (li_raw >= $signed(18'(ni - 1'b1))) begin
      li_sel = INC_W'(ni - 2'd2);
    end else begin
      li_sel = INC_W'(li_raw);
    end
    if (ls_raw[17]) begin
      ls_sel = '0;
    end else if (ls_raw >= $signed(18'(ns - 1'b1))) begin
      ls_sel = SPD_W'(ns - 2'd2);
    end else begin
      ls_sel = SPD_W'(ls_raw);
    end
    lc_dir = DIR_W'(cr >> 16);
    hc_dir = (ND_W'(lc_dir) + 1'b1 == nd) ? '0 : DIR_W'(lc_dir + 1'b1);
    cr_rnd = (CR_W + 1)'(cr) + (CR_W + 1)'(32768);
    nc_raw = ND_W'(cr_rnd >> 16);
    nc_sel = (nc_raw == nd) ? '0 : DIR_W'(nc_raw);
    // high direction point when starting the maximum sweep
    hc_zero = (nd == ND_W'(1)) ? '0 : DIR_W'(1);
  end

  logic [DIR_W-1:0] c_nx, hc_nx;
  assign c_nx  = cur_c + 1'b1;
  assign hc_nx = (ND_W'(c_nx) + 1'b1 == nd) ? '0 : DIR_W'(c_nx + 1'b1);

  logic signed [VAL_W-1:0] best_nx;
  assign best_nx = (cur_c == '0 || lerp_res > best) ? lerp_res : best;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (start) state_next = S_PREP;
      S_PREP: begin
        if (act == ACT_WRITE || kind_bad || row_missing) begin
          state_next = S_FIN;
        end else begin
          state_next = S_MULT;
        end
      end
      S_MULT:  state_next = S_INDEX;
      S_INDEX: state_next = S_READ;
      S_READ:  if (rd_cnt == rd_last) state_next = S_DRAIN;
      S_DRAIN: state_next = (act == ACT_NEAREST) ? S_FIN : S_LERP;
      S_LERP:  state_next = S_WAIT;
      S_WAIT: begin
        if (lerp_done) begin
          if (lstep != 3'(LAST_LERP_STEP)) begin
            state_next = S_LERP;
          end else if (act == ACT_MAXDIR && !last_c) begin
            state_next = S_READ;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_FIN:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control outputs
  always_comb begin
    busy   = (state != S_IDLE);
    done   = (state == S_FIN);
    ram_we = (state == S_PREP) && (act == ACT_WRITE) && wr_ok;
  end

  // memory address: write slot, or one of the eight cube corners
  always_comb begin
    if (state == S_PREP) begin
      ram_addr = {ROW_W'(wrow_q), INC_W'(winc_q), SPD_W'(wspd_q), DIR_W'(wdir_q)};
    end else begin
      ram_addr = {row_q, INC_W'(li + INC_W'(rd_cnt[2])), SPD_W'(ls + SPD_W'(rd_cnt[1])),
                  rd_cnt[0] ? hc : lc};
    end
  end

  // lerp operand selection per step
  always_comb begin
    lreq.start = (state == S_LERP);
    case (lstep)
      3'd0: begin lreq.lo = vals[0]; lreq.hi = vals[1]; lreq.wgt = WGT_W'(wd); end
      3'd1: begin lreq.lo = vals[2]; lreq.hi = vals[3]; lreq.wgt = WGT_W'(wd); end
      3'd2: begin lreq.lo = t0;      lreq.hi = t1;      lreq.wgt = ws; end
      3'd3: begin lreq.lo = vals[4]; lreq.hi = vals[5]; lreq.wgt = WGT_W'(wd); end
      3'd4: begin lreq.lo = vals[6]; lreq.hi = vals[7]; lreq.wgt = WGT_W'(wd); end
      3'd5: begin lreq.lo = t0;      lreq.hi = t1;      lreq.wgt = ws; end
      default: begin lreq.lo = u0;   lreq.hi = u1;      lreq.wgt = wi; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= (state == S_READ);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rd_idx <= rd_cnt;
    if (rd_vld) begin
      vals[rd_idx] <= ram_rdata;
    end
    case (state)
      S_IDLE: begin
        act    <= action_t'(action);
        kind_q <= meas_kind;
        inc_q  <= incidence;
        spd_q  <= speed;
        dir_q  <= direction;
        wrow_q <= write_row;
        winc_q <= write_inc_index;
        wspd_q <= write_spd_index;
        wdir_q <= write_dir_index;
        wval_q <= entry_value;
      end
      S_PREP: begin
        row_q        <= ROW_W'(kind_row);
        d_inc        <= 25'(inc_q) - 25'(inc_min);
        d_spd        <= 25'(spd_q) - 25'(spd_min);
        cr           <= CR_W'(dir_q) * CR_W'(nd);
        result_value <= '0;
        if (act == ACT_WRITE) begin
          status <= ST_OK;
        end else if (kind_bad) begin
          status <= ST_BAD_KIND;
        end else if (row_missing) begin
          status <= ST_NO_ROW;
        end else begin
          status <= ST_OK;
        end
      end
      S_MULT: begin
        ri <= 34'((50'(d_inc) * 50'($signed({1'b0, inc_scale}))) >>> 16);
        rs <= 34'((50'(d_spd) * 50'($signed({1'b0, spd_scale}))) >>> 16);
      end
      S_INDEX: begin
        rd_cnt <= '0;
        lstep  <= '0;
        cur_c  <= '0;
        if (act == ACT_NEAREST) begin
          li      <= ni_sel;
          ls      <= ns_sel;
          lc      <= nc_sel;
          hc      <= nc_sel;
          rd_last <= 3'd0;
        end else begin
          li      <= li_sel;
          ls      <= ls_sel;
          rd_last <= 3'd7;
          if (act == ACT_MAXDIR) begin
            lc <= '0;
            hc <= hc_zero;
            wd <= '0;
          end else begin
            lc <= lc_dir;
            hc <= hc_dir;
            wd <= cr[15:0];
          end
        end
        wi <= ri - $signed({{(WGT_W - INC_W - 16){1'b0}}, li_sel, 16'd0});
        ws <= rs - $signed({{(WGT_W - SPD_W - 16){1'b0}}, ls_sel, 16'd0});
      end
      S_READ: begin
        rd_cnt <= rd_cnt + 1'b1;
      end
      S_DRAIN: begin
        lstep <= '0;
        if (act == ACT_NEAREST) begin
          result_value <= ram_rdata;
        end
      end
      S_WAIT: begin
        if (lerp_done) begin
          lstep <= lstep + 1'b1;
          case (lstep)
            3'd0, 3'd3: t0 <= lerp_res;
            3'd1, 3'd4: t1 <= lerp_res;
            3'd2:       u0 <= lerp_res;
            3'd5:       u1 <= lerp_res;
            default: begin
              if (act == ACT_MAXDIR) begin
                best         <= best_nx;
                result_value <= best_nx;
                cur_c        <= c_nx;
                lc           <= c_nx;
                hc           <= hc_nx;
                rd_cnt       <= '0;
              end else begin
                result_value <= lerp_res;
              end
            end
          endcase
        end
      end
      default: ;
    endcase
  end

  ttli_ram #(
    .WIDTH(VAL_W),
    .DEPTH(DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(wval_q),
    .rdata(ram_rdata)
  );

  ttli_lerp u_lerp (
    .clk   (clk),
    .rst   (rst),
    .req   (lreq),
    .done  (lerp_done),
    .result(lerp_res)
  );

endmodule

### tb/trilinear_table_interpolator_test.sv
// Testbench of the trilinear table interpolator: directed and random items checked
// against a local predictor.
module trilinear_table_interpolator_test;
  import ttli_pkg::*;

  typedef struct {
    action_t          act;
    logic [2:0]       kind;
    logic signed [23:0] inc;
    logic signed [23:0] spd;
    logic [15:0]      dir;
    logic [2:0]       wrow;
    logic [3:0]       winc;
    logic [4:0]       wspd;
    logic [4:0]       wdir;
    logic signed [31:0] value;
  } item_t;

  typedef struct {
    logic signed [31:0] value;
    status_t            st;
  } answer_t;

  logic clk = 0, rst = 1, start = 0, cfg_we = 0;
  logic busy, done;
  logic [1:0] action = 0;
  logic [2:0] meas_kind = 0, write_row = 0, cfg_index = 0;
  logic signed [23:0] incidence = 0, speed = 0;
  logic [15:0] direction = 0;
  logic [3:0] write_inc_index = 0;
  logic [4:0] write_spd_index = 0, write_dir_index = 0;
  logic signed [31:0] entry_value = 0;
  logic signed [31:0] result_value;
  logic [1:0] status;
  logic [23:0] cfg_data = 0;

  trilinear_table_interpolator dut (.*);

  always #1 clk = ~clk;

  // local copy of the table and of the registers
  logic signed [31:0] grid_copy [DEPTH];
  bit                 filled [DEPTH];
  logic signed [23:0] inc_min_r, spd_min_r;
  logic [23:0]        inc_scale_r, spd_scale_r;
  int                 inc_pts_r, spd_pts_r, dir_pts_r, rows_r;

  answer_t pending_answers [$];
  int errors = 0, results_seen = 0, items_sent = 0, idle_pct = 0;

  function automatic longint fl16(longint x);
    return x >>> 16;
  endfunction

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint clampl(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  function automatic longint blend(longint lo, longint hi, longint a);
    longint diff, ah, al;
    diff = hi - lo;
    ah = fl16(a);
    al = a - ah * 65536;
    return sat32(lo + ah * diff + fl16(al * diff + 32768));
  endfunction

  function automatic int cell_addr(int row, int i, int s, int c);
    return ((row * MAX_INC_POINTS + i) * MAX_SPD_POINTS + s) * MAX_DIR_POINTS + c;
  endfunction

  function automatic longint entry(int row, longint i, longint s, longint c);
    return longint'(grid_copy[cell_addr(row, int'(i), int'(s), int'(c))]);
  endfunction

  function automatic longint grid_pos(logic signed [23:0] q, logic signed [23:0] mn,
                                      logic [23:0] scale);
    longint d;
    d = longint'(q) - longint'(mn);
    return fl16(d * longint'({40'd0, scale}));
  endfunction

  function automatic void low_weight(longint r, longint n, output longint lo,
                                     output longint w);
    lo = fl16(r);
    if (lo < 0) lo = 0;
    if (lo + 1 >= n) lo = n - 2;
    w = r - lo * 65536;
  endfunction

  function automatic longint interp3(int row, longint ri, longint rs, longint ni,
                                     longint ns, longint lc, longint hc, longint ac);
    longint li, ai, ls, as, vl, vh;
    longint vi [2];
    low_weight(ri, ni, li, ai);
    low_weight(rs, ns, ls, as);
    for (int k = 0; k < 2; k++) begin
      vl = blend(entry(row, li + k, ls, lc), entry(row, li + k, ls, hc), ac);
      vh = blend(entry(row, li + k, ls + 1, lc), entry(row, li + k, ls + 1, hc), ac);
      vi[k] = blend(vl, vh, as);
    end
    return blend(vi[0], vi[1], ai);
  endfunction

  function automatic int eff_inc();  return int'(clampl(inc_pts_r, 2, MAX_INC_POINTS)); endfunction
  function automatic int eff_spd();  return int'(clampl(spd_pts_r, 2, MAX_SPD_POINTS)); endfunction
  function automatic int eff_dir();  return int'(clampl(dir_pts_r, 1, MAX_DIR_POINTS)); endfunction

  function automatic answer_t predict_lookup(item_t it);
    answer_t ans;
    int row;
    longint ni, ns, nd, ri, rs, cr, val, t, lc;
    ans.value = 0;
    ans.st = ST_OK;
    if (it.act == ACT_WRITE) begin
      grid_copy[cell_addr(int'(it.wrow), int'(it.winc), int'(it.wspd), int'(it.wdir))] = it.value;
      filled[cell_addr(int'(it.wrow), int'(it.winc), int'(it.wspd), int'(it.wdir))] = 1;
      return ans;
    end
    ni = eff_inc(); ns = eff_spd(); nd = eff_dir();
    if (it.kind > 5) begin
      ans.st = ST_BAD_KIND;
      return ans;
    end
    row = (it.kind == 5) ? 4 : int'(it.kind);
    if (row >= rows_r) begin
      ans.st = ST_NO_ROW;
      return ans;
    end
    ri = grid_pos(it.inc, inc_min_r, inc_scale_r);
    rs = grid_pos(it.spd, spd_min_r, spd_scale_r);
    cr = longint'(it.dir) * nd;
    if (it.act == ACT_NEAREST) begin
      val = entry(row, clampl(fl16(ri + 32768), 0, ni - 1),
                  clampl(fl16(rs + 32768), 0, ns - 1), fl16(cr + 32768) % nd);
    end else if (it.act == ACT_TRILIN) begin
      lc = fl16(cr);
      val = interp3(row, ri, rs, ni, ns, lc, (lc + 1) % nd, cr - lc * 65536);
    end else begin
      val = interp3(row, ri, rs, ni, ns, 0, 1 % nd, 0);
      for (longint c = 1; c < nd; c++) begin
        t = interp3(row, ri, rs, ni, ns, c, (c + 1) % nd, 0);
        if (t > val) val = t;
      end
    end
    ans.value = val[31:0];
    return ans;
  endfunction

  // result checker
  initial begin
    answer_t exp_ans;
    forever begin
      @(posedge clk);
      if (!rst && done) begin
        results_seen++;
        if (pending_answers.size() == 0) begin
          $error("result with no pending item: value %0d status %0d", result_value, status);
          errors++;
        end else begin
          exp_ans = pending_answers.pop_front();
          if (result_value !== exp_ans.value) begin
            $error("result_value expected %0d actual %0d", exp_ans.value, result_value);
            errors++;
          end
          if (status !== exp_ans.st) begin
            $error("status expected %0d actual %0d", exp_ans.st, status);
            errors++;
          end
        end
      end
    end
  end

  task automatic send_item(item_t it);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct)
      repeat ($urandom_range(1, 4)) @(negedge clk);
    start = 1;
    action = it.act; meas_kind = it.kind; incidence = it.inc; speed = it.spd;
    direction = it.dir; write_row = it.wrow; write_inc_index = it.winc;
    write_spd_index = it.wspd; write_dir_index = it.wdir; entry_value = it.value;
    do @(posedge clk); while (busy);
    pending_answers.push_back(predict_lookup(it));
    items_sent++;
    @(negedge clk);
    start = 0;
  endtask

  task automatic wait_drained();
    while (pending_answers.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic reg_write(cfg_idx_t idx, logic [23:0] val);
    cfg_we = 1; cfg_index = idx; cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
    case (idx)
      CFG_INC_MIN:   inc_min_r = val;
      CFG_INC_SCALE: inc_scale_r = val;
      CFG_INC_PTS:   inc_pts_r = int'(val[4:0]);
      CFG_SPD_MIN:   spd_min_r = val;
      CFG_SPD_SCALE: spd_scale_r = val;
      CFG_SPD_PTS:   spd_pts_r = int'(val[5:0]);
      CFG_DIR_PTS:   dir_pts_r = int'(val[5:0]);
      CFG_ROWS:      rows_r = int'(val[3:0]);
      default: ;
    endcase
  endtask

  function automatic item_t store_item(int r, int i, int s, int c, logic signed [31:0] v);
    item_t it;
    it = '{act: ACT_WRITE, kind: 3'($urandom), inc: 24'($urandom), spd: 24'($urandom),
           dir: 16'($urandom), wrow: 3'(r), winc: 4'(i), wspd: 5'(s), wdir: 5'(c),
           value: v};
    return it;
  endfunction

  // apply a full register set once nothing is in flight
  task automatic set_regs(logic [23:0] imin, logic [23:0] iscl, logic [23:0] ipts,
                          logic [23:0] smin, logic [23:0] sscl, logic [23:0] spts,
                          logic [23:0] dpts, logic [23:0] rows);
    wait_drained();
    reg_write(CFG_INC_MIN, imin);
    reg_write(CFG_INC_SCALE, iscl);
    reg_write(CFG_INC_PTS, ipts);
    reg_write(CFG_SPD_MIN, smin);
    reg_write(CFG_SPD_SCALE, sscl);
    reg_write(CFG_SPD_PTS, spts);
    reg_write(CFG_DIR_PTS, dpts);
    reg_write(CFG_ROWS, rows);
  endtask

  // apply a full register set, then load every entry a lookup can reach
  task automatic set_grid(logic [23:0] imin, logic [23:0] iscl, logic [23:0] ipts,
                          logic [23:0] smin, logic [23:0] sscl, logic [23:0] spts,
                          logic [23:0] dpts, logic [23:0] rows);
    int saved_idle, nrow;
    set_regs(imin, iscl, ipts, smin, sscl, spts, dpts, rows);
    saved_idle = idle_pct;
    idle_pct = 0;
    nrow = rows_r < 5 ? rows_r : 5;
    for (int r = 0; r < nrow; r++)
      for (int i = 0; i < eff_inc(); i++)
        for (int s = 0; s < eff_spd(); s++)
          for (int c = 0; c < eff_dir(); c++)
            if (!filled[cell_addr(r, i, s, c)])
              send_item(store_item(r, i, s, c, $urandom_range(0, 32'h03ff_ffff) - 32'h0200_0000));
    idle_pct = saved_idle;
  endtask

  // load one incidence/speed cell of a row over all direction points
  task automatic fill_cube(int r, int i0, int s0);
    int saved_idle;
    saved_idle = idle_pct;
    idle_pct = 0;
    for (int i = i0; i < i0 + 2; i++)
      for (int s = s0; s < s0 + 2; s++)
        for (int c = 0; c < eff_dir(); c++)
          if (!filled[cell_addr(r, i, s, c)])
            send_item(store_item(r, i, s, c, $urandom_range(0, 32'h03ff_ffff) - 32'h0200_0000));
    idle_pct = saved_idle;
  endtask

  function automatic item_t query(action_t act, logic [2:0] kind, logic signed [23:0] inc,
                                  logic signed [23:0] spd, logic [15:0] dir);
    item_t it;
    it = store_item($urandom, $urandom, $urandom, $urandom, $urandom);
    it.act = act; it.kind = kind; it.inc = inc; it.spd = spd; it.dir = dir;
    return it;
  endfunction

  task automatic test_directed();
    set_grid(24'd0, 24'd65536, 24'd3, 24'd0, 24'd65536, 24'd3, 24'd4, 24'd5);
    // extreme entry data and the last address of the table
    send_item(store_item(7, 15, 31, 31, 32'sh7fff_ffff));
    send_item(store_item(0, 0, 0, 0, 32'sh7fff_ffff));
    send_item(store_item(0, 1, 0, 0, -32'sh8000_0000));
    send_item(store_item(0, 0, 1, 1, -32'sh8000_0000));
    for (int k = 0; k < 8; k++)
      send_item(query(ACT_TRILIN, 3'(k), 24'h01_8000, 24'h00_c000, 16'h4000));
    send_item(query(ACT_NEAREST, 0, 24'h00_8000, 24'h00_8000, 16'hffff));
    send_item(query(ACT_NEAREST, 1, 24'h7f_ffff, -24'sh80_0000, 16'h0000));
    send_item(query(ACT_NEAREST, 5, -24'sh80_0000, 24'h7f_ffff, 16'h2000));
    // extrapolation beyond both edges, saturating
    send_item(query(ACT_TRILIN, 0, 24'h7f_ffff, 24'h7f_ffff, 16'hffff));
    send_item(query(ACT_TRILIN, 0, -24'sh80_0000, -24'sh80_0000, 16'h0000));
    send_item(query(ACT_TRILIN, 2, 24'h03_4000, -24'sh00_8000, 16'h9000));
    send_item(query(ACT_MAXDIR, 0, 24'h00_4000, 24'h01_2000, 16'h0000));
    send_item(query(ACT_MAXDIR, 4, 24'h7f_ffff, -24'sh80_0000, 16'hffff));
    send_item(query(ACT_MAXDIR, 6, 24'h0, 24'h0, 16'h0));
    // single direction point, too few points clamped, missing rows
    set_grid(24'h80_0000, 24'hff_ffff, 24'd0, 24'h7f_ffff, 24'd0, 24'd1, 24'd1, 24'd2);
    send_item(query(ACT_TRILIN, 0, 24'h00_1234, 24'h55_0000, 16'hc000));
    send_item(query(ACT_NEAREST, 1, -24'sh70_0000, 24'h7f_ffff, 16'hffff));
    send_item(query(ACT_MAXDIR, 1, 24'h12_3456, 24'h00_0000, 16'h1111));
    send_item(query(ACT_TRILIN, 3, 24'h0, 24'h0, 16'h0));
    send_item(query(ACT_NEAREST, 5, 24'h0, 24'h0, 16'h0));
  endtask

  task automatic test_largest_grid();
    // point counts above the limits clamp to the largest grid; queries stay in one
    // incidence/speed cell of rows 0 and 4
    set_regs(24'hff_0000, 24'h00_8000, 24'd31, 24'h00_0000, 24'd65536, 24'd63, 24'd63, 24'd15);
    fill_cube(0, 2, 16);
    fill_cube(4, 2, 16);
    repeat (6)
      send_item(query(action_t'($urandom_range(1, 2)), 3'd0,
                      24'h03_8000 + 24'($urandom_range(0, 16'hffff)),
                      24'h10_0000 + 24'($urandom_range(0, 16'hffff)), 16'($urandom)));
    send_item(query(ACT_MAXDIR, 0, 24'h03_8000, 24'h10_4000, 16'h0));
    send_item(query(ACT_MAXDIR, 5, 24'h03_8000, 24'h10_4000, 16'h0));
  endtask

  function automatic logic signed [23:0] near_axis(logic signed [23:0] mn, int pts);
    if ($urandom_range(9) < 7)
      return 24'(mn + $urandom_range(0, (pts + 2) * 65536) - 65536);
    return 24'($urandom);
  endfunction

  task automatic test_random_phases();
    item_t it;
    int nrow;
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 58 : (ph == 3) ? 34 : 0;
      set_grid(24'($urandom),
               $urandom_range(1) ? 24'd65536 : 24'($urandom_range(24'h0, 24'h04_0000)),
               24'($urandom_range(0, 6)), 24'($urandom),
               $urandom_range(1) ? 24'd65536 : 24'($urandom), 24'($urandom_range(0, 6)),
               24'($urandom_range(0, 5)), 24'($urandom_range(1, 8)));
      nrow = rows_r < 5 ? rows_r : 5;
      for (int n = 0; n < 120; n++) begin
        if (ph == 2 && n == 60) wait_drained();
        if ($urandom_range(99) < 25) begin
          if ($urandom_range(3) == 0)
            it = store_item($urandom, $urandom, $urandom, $urandom, $urandom);
          else
            it = store_item($urandom_range(0, nrow - 1), $urandom_range(0, eff_inc() - 1),
                            $urandom_range(0, eff_spd() - 1), $urandom_range(0, eff_dir() - 1),
                            $urandom_range(0, 32'h03ff_ffff) - 32'h0200_0000);
        end else begin
          it = query(action_t'($urandom_range(1, 3)),
                     3'($urandom_range(9) == 0 ? $urandom_range(6, 7) : $urandom_range(0, 5)),
                     near_axis(inc_min_r, eff_inc()), near_axis(spd_min_r, eff_spd()),
                     16'($urandom));
        end
        send_item(it);
      end
    end
  endtask

  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    inc_min_r = 0; inc_scale_r = 65536; inc_pts_r = 16;
    spd_min_r = 0; spd_scale_r = 65536; spd_pts_r = 32;
    dir_pts_r = 32; rows_r = 5;
    repeat (10) @(negedge clk);
    rst = 0;
    test_directed();
    test_largest_grid();
    test_random_phases();
    wait_drained();
    repeat (2000) @(negedge clk);
    $display("Covered %0d transfers and %0d results: table writes, nearest, trilinear and",
             items_sent, results_seen);
    $display("max-over-direction lookups over several grids, bad kinds and missing rows.");
    if (errors == 0 && pending_answers.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
